FILE: rtl/rpu_pkg.sv
// Shared types and constants for the reaction propensity and update unit.
// Holds the microcode word layout, the step addresses and the microcode ROM.
// No dependencies.
package rpu_pkg;

    // Request codes on req_type.
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_FIRE  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_CLAMP = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACTIVE = 2'd0;
    localparam logic [1:0] CFG_RATE   = 2'd1;
    localparam logic [1:0] CFG_ORDERS = 2'd2;
    localparam logic [1:0] CFG_CHANGE = 2'd3;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // Step addresses of the microprogram.
    localparam upc_t S_IDLE    = 5'd0;
    localparam upc_t S_SET     = 5'd1;
    localparam upc_t S_Q_START = 5'd2;
    localparam upc_t S_Q_CHK   = 5'd3;
    localparam upc_t S_Q_SPEC  = 5'd4;
    localparam upc_t S_Q_TERM  = 5'd5;
    localparam upc_t S_Q_MLO   = 5'd6;
    localparam upc_t S_Q_MHI   = 5'd7;
    localparam upc_t S_Q_ACC   = 5'd8;
    localparam upc_t S_Q_NEXT  = 5'd9;
    localparam upc_t S_Q_RATE  = 5'd10;
    localparam upc_t S_Q_RMLO  = 5'd11;
    localparam upc_t S_Q_RMHI  = 5'd12;
    localparam upc_t S_Q_FINAL = 5'd13;
    localparam upc_t S_Q_BAD   = 5'd14;
    localparam upc_t S_F_START = 5'd15;
    localparam upc_t S_F_STEP  = 5'd16;
    localparam upc_t S_F_END   = 5'd17;
    localparam upc_t S_EMIT    = 5'd18;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_NOP,
        OP_SET,
        OP_Q_INIT,
        OP_TERM,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC,
        OP_NEXT_SP,
        OP_LOAD_RATE,
        OP_FINAL,
        OP_BAD,
        OP_F_INIT,
        OP_F_UPD,
        OP_F_STAT,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_INACTIVE,
        C_BAD_ORDER,
        C_FEW,
        C_K_DONE,
        C_MORE_SP,
        C_RATE_ZERO
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    // Datapath status seen by the sequencer's jump logic.
    typedef struct packed {
        logic inactive;
        logic bad_order;
        logic few;
        logic k_done;
        logic more_sp;
        logic rate_zero;
        logic emit_hold;
    } flags_t;

    function automatic ctrl_t uword(input op_t op, input cond_t cond, input upc_t target);
        ctrl_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // The condition of a step is tested on the state before that step's operation.
    function automatic ctrl_t ucode_rom(input upc_t addr);
        ctrl_t w;
        case (addr)
            S_IDLE:    w = uword(OP_WAIT,      C_NONE,      S_IDLE);
            S_SET:     w = uword(OP_SET,       C_ALWAYS,    S_EMIT);
            S_Q_START: w = uword(OP_Q_INIT,    C_INACTIVE,  S_EMIT);
            S_Q_CHK:   w = uword(OP_NOP,       C_BAD_ORDER, S_Q_BAD);
            S_Q_SPEC:  w = uword(OP_NOP,       C_FEW,       S_EMIT);
            S_Q_TERM:  w = uword(OP_TERM,      C_K_DONE,    S_Q_NEXT);
            S_Q_MLO:   w = uword(OP_MUL_LO,    C_NONE,      S_IDLE);
            S_Q_MHI:   w = uword(OP_MUL_HI,    C_NONE,      S_IDLE);
            S_Q_ACC:   w = uword(OP_ACC,       C_ALWAYS,    S_Q_TERM);
            S_Q_NEXT:  w = uword(OP_NEXT_SP,   C_MORE_SP,   S_Q_SPEC);
            S_Q_RATE:  w = uword(OP_LOAD_RATE, C_RATE_ZERO, S_EMIT);
            S_Q_RMLO:  w = uword(OP_MUL_LO,    C_NONE,      S_IDLE);
            S_Q_RMHI:  w = uword(OP_MUL_HI,    C_NONE,      S_IDLE);
            S_Q_FINAL: w = uword(OP_FINAL,     C_ALWAYS,    S_EMIT);
            S_Q_BAD:   w = uword(OP_BAD,       C_ALWAYS,    S_EMIT);
            S_F_START: w = uword(OP_F_INIT,    C_INACTIVE,  S_EMIT);
            S_F_STEP:  w = uword(OP_F_UPD,     C_MORE_SP,   S_F_STEP);
            S_F_END:   w = uword(OP_F_STAT,    C_NONE,      S_IDLE);
            S_EMIT:    w = uword(OP_EMIT,      C_ALWAYS,    S_IDLE);
            default:   w = uword(OP_NOP,       C_ALWAYS,    S_IDLE);
        endcase
        return w;
    endfunction

    // Entry step of the microprogram for each request type.
    function automatic upc_t dispatch(input logic [1:0] req);
        upc_t a;
        unique case (req)
            REQ_SET:   a = S_SET;
            REQ_QUERY: a = S_Q_START;
            REQ_FIRE:  a = S_F_START;
            default:   a = S_EMIT;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/rpu_seq.sv
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on rpu_pkg for the control word, flags and the microcode ROM.
module rpu_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      req_type,
    input  rpu_pkg::flags_t flags,
    output rpu_pkg::ctrl_t  ctrl
);

    rpu_pkg::upc_t upc_reg;
    rpu_pkg::upc_t upc_next;
    logic          taken;

    assign ctrl = rpu_pkg::ucode_rom(upc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            rpu_pkg::C_NONE:      taken = 1'b0;
            rpu_pkg::C_ALWAYS:    taken = 1'b1;
            rpu_pkg::C_INACTIVE:  taken = flags.inactive;
            rpu_pkg::C_BAD_ORDER: taken = flags.bad_order;
            rpu_pkg::C_FEW:       taken = flags.few;
            rpu_pkg::C_K_DONE:    taken = flags.k_done;
            rpu_pkg::C_MORE_SP:   taken = flags.more_sp;
            rpu_pkg::C_RATE_ZERO: taken = flags.rate_zero;
            default:              taken = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (ctrl.op == rpu_pkg::OP_WAIT)
        begin
            upc_next = start ? rpu_pkg::dispatch(req_type) : upc_reg;
        end
        else if (ctrl.op == rpu_pkg::OP_EMIT && flags.emit_hold)
        begin
            // The previous result is still waiting in the output register.
            upc_next = upc_reg;
        end
        else if (taken)
        begin
            upc_next = ctrl.target;
        end
        else
        begin
            upc_next = upc_reg + rpu_pkg::upc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= rpu_pkg::S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: rtl/reaction_propensity_and_update_unit.sv
// Top level of the reaction propensity and update unit: count store, datapath, output register.
// Depends on rpu_pkg and rpu_seq.
//
// One request is worked at a time by a microcoded sequence over one shared
// 32x32 multiplier. A fire request updates one species per cycle. In a query,
// each factor of the falling factorial costs two multiplier passes (low and
// high half of the 64-bit product) plus an accumulate step; an inactive or
// bad-order query ends early, and a species with too few molecules ends the
// walk early. The result sits in an output register, so the next request is
// taken while it waits; a request only stalls at its last step if that
// register is still full.
module reaction_propensity_and_update_unit #(
    parameter int NSPECS      = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [3:0]  species,
    input  logic [31:0] count_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] propensity,
    output logic [1:0]  status
);

    localparam int SP_W = (NSPECS > 1) ? $clog2(NSPECS) : 1;
    localparam int FW   = COUNT_WIDTH + 2;

    rpu_pkg::ctrl_t  ctrl;
    rpu_pkg::flags_t flags;
    logic            in_accept;

    // Configuration registers.
    logic        active_reg;
    logic [31:0] rate_reg;
    logic [47:0] orders_reg;
    logic [63:0] change_reg;

    // Molecule counts.
    logic [COUNT_WIDTH-1:0] cnt_reg [NSPECS];
    logic                   cnt_wen;
    logic [SP_W-1:0]        cnt_widx;
    logic [COUNT_WIDTH-1:0] cnt_wdata;

    // Datapath registers.
    logic [3:0]             req_species_reg;
    logic [COUNT_WIDTH-1:0] req_count_reg;
    logic [SP_W-1:0]        sp_reg, sp_next;
    logic [2:0]             k_reg, k_next;
    logic [63:0]            h_reg, h_next;
    logic                   sat_reg, sat_next;
    logic                   clamp_reg, clamp_next;
    logic [31:0]            b_reg, b_next;
    logic [63:0]            plo_reg, plo_next;
    logic [63:0]            phi_reg, phi_next;
    logic [63:0]            res_prop_reg, res_prop_next;
    logic [1:0]             res_status_reg, res_status_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] propensity_reg;
    logic [1:0]  status_reg;

    logic [2:0]             ord_arr [NSPECS];
    logic signed [3:0]      delta_arr [NSPECS];
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [2:0]             ord_cur;
    logic signed [3:0]      delta_cur;
    logic                   bad_order;
    logic [31:0]            mul_a;
    logic [63:0]            mul_p;
    logic [64:0]            comb_sum;
    logic                   comb_ovf;
    logic signed [FW-1:0]   fire_sum;
    logic [COUNT_WIDTH-1:0] fire_val;
    logic                   fire_clamp;
    logic                   emit_go;

    rpu_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .req_type (req_type),
        .flags    (flags),
        .ctrl     (ctrl)
    );

    assign in_stall  = (ctrl.op != rpu_pkg::OP_WAIT);
    assign in_accept = in_valid && !in_stall;

    for (genvar i = 0; i < NSPECS; i++)
    begin : g_unpack
        assign ord_arr[i]   = orders_reg[3*i +: 3];
        assign delta_arr[i] = change_reg[4*i +: 4];
    end

    always_comb
    begin
        bad_order = 1'b0;
        for (int i = 0; i < NSPECS; i++)
        begin
            bad_order = bad_order | (ord_arr[i][2] & (ord_arr[i][1] | ord_arr[i][0]));
        end
    end

    assign cnt_cur   = cnt_reg[sp_reg];
    assign ord_cur   = ord_arr[sp_reg];
    assign delta_cur = delta_arr[sp_reg];

    assign flags.inactive  = !active_reg;
    assign flags.bad_order = bad_order;
    assign flags.few       = (cnt_cur < COUNT_WIDTH'(ord_cur));
    assign flags.k_done    = (k_reg == ord_cur);
    assign flags.more_sp   = (sp_reg != SP_W'(NSPECS - 1));
    assign flags.rate_zero = (rate_reg == 32'd0);
    assign flags.emit_hold = out_valid_reg && out_stall;

    // A 64 x 32 product is formed from two 32 x 32 halves; the high half is
    // shifted up by 32 and any bit beyond 64 means saturation.
    assign mul_a    = (ctrl.op == rpu_pkg::OP_MUL_HI) ? h_reg[63:32] : h_reg[31:0];
    assign mul_p    = mul_a * b_reg;
    assign comb_sum = {1'b0, phi_reg[31:0], 32'd0} + {1'b0, plo_reg};
    assign comb_ovf = (phi_reg[63:32] != 32'd0) || comb_sum[64];

    always_comb
    begin
        fire_sum   = $signed({2'b00, cnt_cur}) + FW'(delta_cur);
        fire_clamp = 1'b0;
        fire_val   = fire_sum[COUNT_WIDTH-1:0];
        if (fire_sum[FW-1])
        begin
            fire_val   = '0;
            fire_clamp = 1'b1;
        end
        else if (fire_sum[COUNT_WIDTH])
        begin
            fire_val   = '1;
            fire_clamp = 1'b1;
        end
    end

    always_comb
    begin
        sp_next         = sp_reg;
        k_next          = k_reg;
        h_next          = h_reg;
        sat_next        = sat_reg;
        clamp_next      = clamp_reg;
        b_next          = b_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        res_prop_next   = res_prop_reg;
        res_status_next = res_status_reg;
        cnt_wen         = 1'b0;
        cnt_widx        = sp_reg;
        cnt_wdata       = fire_val;

        if (in_accept)
        begin
            res_prop_next   = 64'd0;
            res_status_next = rpu_pkg::ST_OK;
        end

        case (ctrl.op)
            rpu_pkg::OP_SET:
            begin
                cnt_wen   = ({1'b0, req_species_reg} < 5'(NSPECS));
                cnt_widx  = req_species_reg[SP_W-1:0];
                cnt_wdata = req_count_reg;
            end
            rpu_pkg::OP_Q_INIT:
            begin
                h_next   = 64'd1;
                sat_next = 1'b0;
                sp_next  = '0;
                k_next   = 3'd0;
            end
            rpu_pkg::OP_TERM:
            begin
                b_next = 32'(cnt_cur - COUNT_WIDTH'(k_reg));
                k_next = k_reg + 3'd1;
            end
            rpu_pkg::OP_MUL_LO:
            begin
                plo_next = mul_p;
            end
            rpu_pkg::OP_MUL_HI:
            begin
                phi_next = mul_p;
            end
            rpu_pkg::OP_ACC:
            begin
                h_next   = comb_ovf ? '1 : comb_sum[63:0];
                sat_next = sat_reg | comb_ovf;
            end
            rpu_pkg::OP_NEXT_SP:
            begin
                sp_next = sp_reg + SP_W'(1);
                k_next  = 3'd0;
            end
            rpu_pkg::OP_LOAD_RATE:
            begin
                b_next = rate_reg;
            end
            rpu_pkg::OP_FINAL:
            begin
                if (sat_reg || comb_ovf)
                begin
                    res_prop_next   = '1;
                    res_status_next = rpu_pkg::ST_SAT;
                end
                else
                begin
                    res_prop_next   = comb_sum[63:0];
                    res_status_next = rpu_pkg::ST_OK;
                end
            end
            rpu_pkg::OP_BAD:
            begin
                res_status_next = rpu_pkg::ST_ORDER;
            end
            rpu_pkg::OP_F_INIT:
            begin
                sp_next    = '0;
                clamp_next = 1'b0;
            end
            rpu_pkg::OP_F_UPD:
            begin
                cnt_wen    = 1'b1;
                clamp_next = clamp_reg | fire_clamp;
                sp_next    = sp_reg + SP_W'(1);
            end
            rpu_pkg::OP_F_STAT:
            begin
                res_status_next = clamp_reg ? rpu_pkg::ST_CLAMP : rpu_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    assign emit_go = (ctrl.op == rpu_pkg::OP_EMIT) && !flags.emit_hold;

    always_comb
    begin
        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            rate_reg   <= 32'd0;
            orders_reg <= 48'd0;
            change_reg <= 64'd0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                rpu_pkg::CFG_ACTIVE: active_reg <= cfg_data[0];
                rpu_pkg::CFG_RATE:   rate_reg   <= cfg_data[31:0];
                rpu_pkg::CFG_ORDERS: orders_reg <= cfg_data[47:0];
                rpu_pkg::CFG_CHANGE: change_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSPECS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cnt_wen)
        begin
            cnt_reg[cnt_widx] <= cnt_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_species_reg <= species;
            req_count_reg   <= count_value[COUNT_WIDTH-1:0];
        end
        sp_next_dummy_free: begin
        end
        sp_reg         <= sp_next;
        k_reg          <= k_next;
        h_reg          <= h_next;
        sat_reg        <= sat_next;
        clamp_reg      <= clamp_next;
        b_reg          <= b_next;
        plo_reg        <= plo_next;
        phi_reg        <= phi_next;
        res_prop_reg   <= res_prop_next;
        res_status_reg <= res_status_next;
        if (emit_go)
        begin
            propensity_reg <= res_prop_reg;
            status_reg     <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign propensity = propensity_reg;
    assign status     = status_reg;

endmodule

FILE: rtl/rpu_checker.sv
// Port-level checker for the reaction propensity and update unit, with its bind.
// Depends on rpu_pkg for the status codes.
module rpu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] propensity,
    input logic [1:0]  status
);

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(propensity) && $stable(status))
        else $error("result changed while stalled");

    // Only one request is in progress: acceptance closes the input at once.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a request was taken");

    // A saturated propensity reads as all ones.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rpu_pkg::ST_SAT |-> propensity == 64'hFFFF_FFFF_FFFF_FFFF)
        else $error("saturated status without all-ones propensity");

    // Order errors and clamped fire results carry no propensity.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == rpu_pkg::ST_ORDER || status == rpu_pkg::ST_CLAMP)
        |-> propensity == 64'd0)
        else $error("nonzero propensity with order or clamp status");

endmodule

bind reaction_propensity_and_update_unit rpu_checker u_rpu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .propensity (propensity),
    .status     (status)
);

FILE: tb/reaction_propensity_and_update_unit_tb.sv
// Testbench for reaction_propensity_and_update_unit: a directed table of requests, then random
// requests under changing register settings, each result checked against a typed expectation or a local predictor.
// Depends on rpu_pkg and the unit's RTL.
module reaction_propensity_and_update_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpu_pkg::*;

    localparam int NSPECS         = 16;
    localparam int COUNT_WIDTH    = 32;
    localparam longint COUNT_MAX  = (longint'(1) << COUNT_WIDTH) - 1;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int EPOCHS         = 26;
    localparam int EPOCH_ITEMS    = 50;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [63:0] prop;
        logic [1:0]  st;
    } outcome_t;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

    // For a register row, code is the register index and data the value written.
    typedef struct {
        row_kind_e   kind;
        logic [1:0]  code;
        logic [3:0]  sp;
        logic [63:0] data;
        bit          typed;
        logic [63:0] prop;
        logic [1:0]  st;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [3:0]  species;
    logic [31:0] count_value;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] propensity;
    logic [1:0]  status;

    // Predictor copy of the registers and the count store.
    logic                   site_active;
    logic [31:0]            site_rate;
    logic [47:0]            site_orders;
    logic [63:0]            site_change;
    logic [COUNT_WIDTH-1:0] site_counts [NSPECS];

    outcome_t awaited_outcomes [$];

    int error_count  = 0;
    int quiet_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    reaction_propensity_and_update_unit #(
        .NSPECS     (NSPECS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] capped_product(input logic [63:0] a, input logic [63:0] b,
                                                   inout bit ovf);
        logic [127:0] full;
        full = {64'd0, a} * {64'd0, b};
        if (full[127:64] != 64'd0)
        begin
            ovf = 1'b1;
            return '1;
        end
        return full[63:0];
    endfunction

    function automatic void query_propensity(output logic [63:0] prop, output logic [1:0] st);
        logic [63:0] h;
        logic [63:0] cnt;
        logic [2:0]  ord;
        bit          ovf;
        prop = '0;
        st   = ST_OK;
        h    = 64'd1;
        ovf  = 1'b0;
        if (!site_active)
            return;
        for (int i = 0; i < NSPECS; i++)
        begin
            if (site_orders[3*i +: 3] > 3'd4)
            begin
                st = ST_ORDER;
                return;
            end
        end
        for (int i = 0; i < NSPECS; i++)
        begin
            ord = site_orders[3*i +: 3];
            cnt = 64'(site_counts[i]);
            // Too few molecules wins even over a product that already saturated.
            if (cnt < 64'(ord))
                return;
            for (int k = 0; k < ord; k++)
                h = capped_product(h, cnt - 64'(k), ovf);
        end
        if (site_rate == 32'd0)
            return;
        prop = capped_product(h, 64'(site_rate), ovf);
        if (ovf)
        begin
            prop = '1;
            st   = ST_SAT;
        end
    endfunction

    function automatic logic [1:0] fire_reaction();
        longint     v;
        logic [3:0] nib;
        bit         clamped;
        clamped = 1'b0;
        if (!site_active)
            return ST_OK;
        for (int i = 0; i < NSPECS; i++)
        begin
            nib = site_change[4*i +: 4];
            v   = longint'(site_counts[i]) + longint'($signed(nib));
            if (v < 0)
            begin
                v       = 0;
                clamped = 1'b1;
            end
            else if (v > COUNT_MAX)
            begin
                v       = COUNT_MAX;
                clamped = 1'b1;
            end
            site_counts[i] = v[COUNT_WIDTH-1:0];
        end
        return clamped ? ST_CLAMP : ST_OK;
    endfunction

    function automatic outcome_t step_reaction_site(input logic [1:0] req, input logic [3:0] sp,
                                                    input logic [31:0] val);
        outcome_t o;
        o.prop = '0;
        o.st   = ST_OK;
        case (req)
            REQ_SET:
                if (sp < NSPECS)
                    site_counts[sp] = val[COUNT_WIDTH-1:0];
            REQ_QUERY:
                query_propensity(o.prop, o.st);
            REQ_FIRE:
                o.st = fire_reaction();
            default:
                ;
        endcase
        return o;
    endfunction

    function automatic logic [31:0] random_count();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return $urandom_range(12);
        if (pick < 65)
            return $urandom_range(100000, 13);
        if (pick < 85)
            return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(15);
    endfunction

    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_ACTIVE: site_active = value[0];
            CFG_RATE:   site_rate   = value[31:0];
            CFG_ORDERS: site_orders = value[47:0];
            CFG_CHANGE: site_change = value;
        endcase
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offers one request and records its expected result once it is taken.
    task automatic issue_request(input logic [1:0] req, input logic [3:0] sp,
                                 input logic [31:0] val, input bit typed,
                                 input outcome_t typed_out);
        outcome_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        species     <= sp;
        count_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        predicted = step_reaction_site(req, sp, val);
        awaited_outcomes.push_back(typed ? typed_out : predicted);
    endtask

    task automatic send_random_request();
        int unsigned pick;
        logic [1:0]  req;
        outcome_t    none;
        pick = $urandom_range(99);
        if (pick < 45)
            req = REQ_SET;
        else if (pick < 80)
            req = REQ_QUERY;
        else if (pick < 97)
            req = REQ_FIRE;
        else
            req = REQ_UNKNOWN;
        none = '0;
        issue_request(req, 4'($urandom_range(15)), random_count(), 1'b0, none);
    endtask

    task automatic reconfigure_site(input bit with_bad_order);
        logic [31:0] rate;
        logic [47:0] orders;
        logic [63:0] change;
        int unsigned density;
        case ($urandom_range(4))
            0:       rate = '0;
            1:       rate = 32'h0001_0000;
            2:       rate = '1;
            3:       rate = $urandom_range(32'h3_FFFF);
            default: rate = $urandom;
        endcase
        // Keep most species out of the reaction so that queries often reach the rate multiply.
        density = $urandom_range(40);
        orders  = '0;
        for (int i = 0; i < NSPECS; i++)
            if ($urandom_range(99) < density)
                orders[3*i +: 3] = 3'($urandom_range(4, 1));
        if (with_bad_order)
            orders[3*$urandom_range(15) +: 3] = 3'($urandom_range(7, 5));
        case ($urandom_range(9))
            0:       change = '0;
            1:       change = {16{4'h8}};
            2:       change = {16{4'h7}};
            default: change = {$urandom, $urandom};
        endcase
        write_register(CFG_ACTIVE, 64'($urandom_range(99) < 85));
        write_register(CFG_RATE, 64'(rate));
        write_register(CFG_ORDERS, 64'(orders));
        write_register(CFG_CHANGE, change);
    endtask

    // Result side: one stall decision per cycle, with a long hold-off when one is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_asked != hold_served)
            begin
                hold_served++;
                hold_left = LONG_HOLD;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else if (out_valid && !out_stall)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("unexpected result: propensity %h, status %0d", propensity, status);
                    error_count++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (propensity !== want.prop)
                    begin
                        $error("propensity: expected %h, got %h", want.prop, propensity);
                        error_count++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        plan_row_t plan [$];
        outcome_t  typed_out;

        rst_n       = 1'b0;
        cfg_wen     = 1'b0;
        cfg_index   = CFG_ACTIVE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        req_type    = REQ_SET;
        species     = '0;
        count_value = '0;

        site_active = 1'b1;
        site_rate   = '0;
        site_orders = '0;
        site_change = '0;
        foreach (site_counts[i])
            site_counts[i] = '0;

        // Reset state: no orders, so h is one and a zero rate gives zero.
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b1, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_RATE, 4'd0, 64'h1_0000, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b1, 64'h1_0000, ST_OK});
        plan.push_back('{ROW_REQ, REQ_SET, 4'd0, 64'hFFFF_FFFF, 1'b1, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_SET, 4'd15, 64'd0, 1'b1, 64'd0, ST_OK});
        // A full count to the fourth power overflows the product.
        plan.push_back('{ROW_CFG, CFG_ORDERS, 4'd0, 64'h4, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b1, '1, ST_SAT});
        // Species 15 is empty: too few molecules after the overflow still gives zero.
        plan.push_back('{ROW_CFG, CFG_ORDERS, 4'd0, 64'h2000_0000_0004, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b1, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_ORDERS, 4'd0, 64'hE000_0000_0000, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b1, 64'd0, ST_ORDER});
        plan.push_back('{ROW_CFG, CFG_ORDERS, 4'd0, 64'hA00, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b1, 64'd0, ST_ORDER});
        // Inactive overrides the bad order and blocks the fire.
        plan.push_back('{ROW_CFG, CFG_ACTIVE, 4'd0, 64'd0, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b1, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_CHANGE, 4'd0, 64'hF000_0000_0000_0001, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_FIRE, 4'd0, 64'd0, 1'b1, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_ACTIVE, 4'd0, 64'd1, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_ORDERS, 4'd0, 64'd0, 1'b0, 64'd0, ST_OK});
        // Species 0 clamps at the top, species 15 at zero.
        plan.push_back('{ROW_REQ, REQ_FIRE, 4'd0, 64'd0, 1'b1, 64'd0, ST_CLAMP});
        plan.push_back('{ROW_REQ, REQ_UNKNOWN, 4'd15, 64'hFFFF_FFFF, 1'b1, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_RATE, 4'd0, 64'hFFFF_FFFF, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b1, 64'hFFFF_FFFF, ST_OK});
        plan.push_back('{ROW_REQ, REQ_SET, 4'd5, 64'd7, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_SET, 4'd7, 64'h1234_5678, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_ORDERS, 4'd0, 64'h41_8000, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_RATE, 4'd0, 64'h8000, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_CHANGE, 4'd0, {16{4'h8}}, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_FIRE, 4'd0, 64'd0, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_CHANGE, 4'd0, {16{4'h7}}, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_FIRE, 4'd0, 64'd0, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b0, 64'd0, ST_OK});
        // An overflowing product times a zero rate is a plain zero.
        plan.push_back('{ROW_CFG, CFG_ORDERS, 4'd0, 64'h4, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_CFG, CFG_RATE, 4'd0, 64'd0, 1'b0, 64'd0, ST_OK});
        plan.push_back('{ROW_REQ, REQ_QUERY, 4'd0, 64'd0, 1'b1, 64'd0, ST_OK});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            if (plan[n].kind == ROW_CFG)
            begin
                wait_until_drained();
                write_register(plan[n].code, plan[n].data);
            end
            else
            begin
                typed_out.prop = plan[n].prop;
                typed_out.st   = plan[n].st;
                issue_request(plan[n].code, plan[n].sp, plan[n].data[31:0], plan[n].typed,
                              typed_out);
            end
        end

        for (int ep = 0; ep < EPOCHS; ep++)
        begin
            wait_until_drained();
            if (ep < 9)
            begin
                tx_idle_pct = 8;
                rx_idle_pct = 70;
            end
            else if (ep < 18)
            begin
                tx_idle_pct = 70;
                rx_idle_pct = 8;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            reconfigure_site($urandom_range(99) < 15);
            // The result side holds off while requests keep coming, so the input backs up.
            if (ep == 4 || ep == 20)
                hold_asked++;
            for (int n = 0; n < EPOCH_ITEMS; n++)
                send_random_request();
        end

        wait_until_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
